### rtl/kic_pkg.sv
package kic_pkg;

  // Characters held before digit and operator keys are refused.
  localparam int MAX_CHARS = 62;

  // Width of the arithmetic word and the number of shift-and-add or
  // shift-and-subtract steps it takes.
  localparam int WORD_BITS = 64;

  // Powers of ten from ten up to ten to the nineteenth, compared in turn.
  localparam int POW_COUNT = 19;

  typedef enum logic [2:0] {
    ACT_DIGIT = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_DIV   = 3'd4,
    ACT_EQ    = 3'd5,
    ACT_CLEAR = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DVFIX,
    ST_FIN,
    ST_LEN,
    ST_EMIT
  } state_t;

  // Two's complement magnitude; the minimum value maps to itself.
  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // Ten to the power (i + 1).
  function automatic logic [63:0] pow10(input logic [4:0] i);
    unique case (i)
      5'd0:    pow10 = 64'd10;
      5'd1:    pow10 = 64'd100;
      5'd2:    pow10 = 64'd1000;
      5'd3:    pow10 = 64'd10000;
      5'd4:    pow10 = 64'd100000;
      5'd5:    pow10 = 64'd1000000;
      5'd6:    pow10 = 64'd10000000;
      5'd7:    pow10 = 64'd100000000;
      5'd8:    pow10 = 64'd1000000000;
      5'd9:    pow10 = 64'd10000000000;
      5'd10:   pow10 = 64'd100000000000;
      5'd11:   pow10 = 64'd1000000000000;
      5'd12:   pow10 = 64'd10000000000000;
      5'd13:   pow10 = 64'd100000000000000;
      5'd14:   pow10 = 64'd1000000000000000;
      5'd15:   pow10 = 64'd10000000000000000;
      5'd16:   pow10 = 64'd100000000000000000;
      5'd17:   pow10 = 64'd1000000000000000000;
      5'd18:   pow10 = 64'd10000000000000000000;
      default: pow10 = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

endpackage

### rtl/keypad_integer_calculator.sv
// Digit, add and subtract keys are done in the idle state; a multiply and a
// divide by a nonzero operand step one bit of the shared shift register per
// cycle, the divide then fixing its sign in ST_DVFIX. Equals adds a decimal
// length scan over 19 powers of ten, one compare per cycle, after the pending
// operation. One key is in work at a time; the output register lets the
// next key enter while a result waits. Reset (rst, synchronous,
// active high) clears the calculator state to zero with add pending.
module keypad_integer_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [63:0] result, [68:64] shown_length, [71:69] zero
);

  localparam int W = kic_pkg::WORD_BITS;

  // Architectural calculator state.
  logic [W-1:0]     acc;
  logic [W-1:0]     opnd;
  kic_pkg::op_t     pend;
  logic [5:0]       chars;

  // Shared serial datapath. For a multiply, wa is the shifted multiplicand,
  // wb the multiplier shifting out and wc the partial product. For a divide,
  // wa is the divisor magnitude, wb the dividend shifting out while quotient
  // bits shift in, and wc the partial remainder. For the length scan, wa
  // holds the magnitude of the result.
  logic [W-1:0]     wa;
  logic [W-1:0]     wb;
  logic [W-1:0]     wc;
  logic [5:0]       cnt;
  logic             neg;
  logic             is_eq;
  logic [4:0]       lenr;

  logic [W-1:0]     out_res;
  logic [4:0]       out_len;
  logic             out_valid;

  kic_pkg::state_t  state;
  kic_pkg::state_t  state_next;

  kic_pkg::action_t act;
  kic_pkg::op_t     new_op;
  logic [3:0]       digit;
  logic             beat_in;
  logic             full;
  logic             go_apply;
  logic             out_free;
  kic_pkg::state_t  post_apply;

  logic [W-1:0]     opnd_x10;
  logic [W-1:0]     mul_sum;
  logic [W:0]       trial;
  logic             div_ge;
  logic [W:0]       div_diff;
  logic             len_ge;

  assign act      = kic_pkg::action_t'(s_axis_tuser);
  assign digit    = s_axis_tdata[3:0];
  assign beat_in  = s_axis_tvalid && s_axis_tready;
  assign full     = chars >= 6'(kic_pkg::MAX_CHARS);
  assign out_free = !out_valid || m_axis_tready;

  // Operand times ten is two shifted copies added.
  assign opnd_x10 = {opnd[W-4:0], 3'b000} + {opnd[W-2:0], 1'b0};
  assign mul_sum  = wc + (wb[0] ? wa : '0);

  // Restoring division step: bring down the next dividend bit and try the divisor.
  assign trial    = {wc, wb[W-1]};
  assign div_diff = trial - {1'b0, wa};
  assign div_ge   = trial >= {1'b0, wa};

  assign len_ge   = wa >= kic_pkg::pow10(cnt[4:0]);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_len, out_res};

  // Key decode and next state.
  always_comb begin
    s_axis_tready = (state == kic_pkg::ST_IDLE);
    go_apply      = 1'b0;
    new_op        = kic_pkg::OP_ADD;
    post_apply    = is_eq ? kic_pkg::ST_FIN : kic_pkg::ST_IDLE;
    state_next    = state;

    unique case (act)
      kic_pkg::ACT_SUB: new_op = kic_pkg::OP_SUB;
      kic_pkg::ACT_MUL: new_op = kic_pkg::OP_MUL;
      kic_pkg::ACT_DIV: new_op = kic_pkg::OP_DIV;
      default:          new_op = kic_pkg::OP_ADD;
    endcase

    unique case (state)
      kic_pkg::ST_IDLE: begin
        if (beat_in) begin
          unique case (act)
            kic_pkg::ACT_EQ: go_apply = 1'b1;
            kic_pkg::ACT_ADD, kic_pkg::ACT_SUB,
            kic_pkg::ACT_MUL, kic_pkg::ACT_DIV: go_apply = !full;
            default: go_apply = 1'b0;
          endcase
          if (go_apply) begin
            priority if (pend == kic_pkg::OP_MUL) begin
              state_next = kic_pkg::ST_MUL;
            end else if (pend == kic_pkg::OP_DIV && opnd != '0) begin
              state_next = kic_pkg::ST_DIV;
            end else if (act == kic_pkg::ACT_EQ) begin
              state_next = kic_pkg::ST_FIN;
            end else begin
              state_next = kic_pkg::ST_IDLE;
            end
          end
        end
      end
      kic_pkg::ST_MUL: begin
        if (cnt == 6'(W - 1)) state_next = post_apply;
      end
      kic_pkg::ST_DIV: begin
        if (cnt == 6'(W - 1)) state_next = kic_pkg::ST_DVFIX;
      end
      kic_pkg::ST_DVFIX: state_next = post_apply;
      kic_pkg::ST_FIN:   state_next = kic_pkg::ST_LEN;
      kic_pkg::ST_LEN: begin
        if (cnt == 6'(kic_pkg::POW_COUNT - 1)) state_next = kic_pkg::ST_EMIT;
      end
      kic_pkg::ST_EMIT: begin
        if (out_free) state_next = kic_pkg::ST_IDLE;
      end
      default: state_next = kic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kic_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Calculator state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      opnd      <= '0;
      pend      <= kic_pkg::OP_ADD;
      chars     <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the emit state a new result takes the place of the one leaving.
      if (out_valid && m_axis_tready && state != kic_pkg::ST_EMIT) out_valid <= 1'b0;

      unique case (state)
        kic_pkg::ST_IDLE: begin
          if (beat_in) begin
            if (act == kic_pkg::ACT_CLEAR) begin
              acc   <= '0;
              opnd  <= '0;
              pend  <= kic_pkg::OP_ADD;
              chars <= '0;
            end else if (act == kic_pkg::ACT_DIGIT && digit <= 4'd9 && !full) begin
              opnd  <= opnd_x10 + W'(digit);
              chars <= chars + 6'd1;
            end else if (go_apply) begin
              is_eq <= (act == kic_pkg::ACT_EQ);
              opnd  <= '0;
              cnt   <= '0;
              wc    <= '0;
              if (act != kic_pkg::ACT_EQ) begin
                pend  <= new_op;
                chars <= chars + 6'd1;
              end
              unique case (pend)
                kic_pkg::OP_ADD: acc <= acc + opnd;
                kic_pkg::OP_SUB: acc <= acc - opnd;
                kic_pkg::OP_MUL: begin
                  wa <= acc;
                  wb <= opnd;
                end
                kic_pkg::OP_DIV: begin
                  // A zero divisor leaves the accumulator as it is.
                  wa  <= kic_pkg::mag(opnd);
                  wb  <= kic_pkg::mag(acc);
                  neg <= acc[W-1] ^ opnd[W-1];
                end
                default: acc <= acc;
              endcase
            end
          end
        end
        kic_pkg::ST_MUL: begin
          wc  <= mul_sum;
          wa  <= {wa[W-2:0], 1'b0};
          wb  <= {1'b0, wb[W-1:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(W - 1)) acc <= mul_sum;
        end
        kic_pkg::ST_DIV: begin
          wc  <= div_ge ? div_diff[W-1:0] : trial[W-1:0];
          wb  <= {wb[W-2:0], div_ge};
          cnt <= cnt + 6'd1;
        end
        kic_pkg::ST_DVFIX: begin
          // The minimum divided by minus one comes out as the minimum again.
          acc <= neg ? (~wb + 1'b1) : wb;
        end
        kic_pkg::ST_FIN: begin
          wa   <= kic_pkg::mag(acc);
          neg  <= acc[W-1];
          lenr <= 5'd1 + 5'(acc[W-1]);
          cnt  <= '0;
        end
        kic_pkg::ST_LEN: begin
          if (len_ge) lenr <= lenr + 5'd1;
          cnt <= cnt + 6'd1;
        end
        kic_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res   <= acc;
            out_len   <= lenr;
            // Reload as if the shown text had been typed afresh.
            acc       <= '0;
            opnd      <= wa;
            pend      <= neg ? kic_pkg::OP_SUB : kic_pkg::OP_ADD;
            chars     <= {1'b0, lenr};
          end
        end
        default: acc <= acc;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_chars_bound: assert property (@(posedge clk) disable iff (rst)
    chars <= 6'(kic_pkg::MAX_CHARS))
    else $error("character count above limit");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len >= 5'd1 && out_len <= 5'd20))
    else $error("shown length out of range");

  a_len_mag: assert property (@(posedge clk) disable iff (rst)
    (state == kic_pkg::ST_LEN && wa[W-1]) |-> (neg && wa[W-2:0] == '0))
    else $error("magnitude top bit set for a value other than the minimum");

  a_mul_runs: assert property (@(posedge clk) disable iff (rst)
    (state == kic_pkg::ST_MUL && cnt != 6'(W - 1)) |=> state == kic_pkg::ST_MUL)
    else $error("multiply left early");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == kic_pkg::ST_EMIT && out_free) |=> (out_valid && acc == '0))
    else $error("equals did not load the output register");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // The calculator takes its keys on the slave stream and returns one beat per
  // equals key on the master stream. Each key that is handed over is also fed
  // to a behavioral copy of the calculator kept here, and every equals key
  // leaves the value and text length that the hardware must produce.

  // Action code that names no key; the block must ignore it.
  localparam logic [2:0] ACT_NONE = 3'd7;

  // Time given to the block to settle once no results are owed.
  localparam int SETTLE_CYCLES = 100;
  // Beats the random part hands over, not counting ignored keys.
  localparam int RANDOM_KEYS = 925;
  // Results the random part keeps going for at the least.
  localparam int RANDOM_RESULTS = 60;
  // Cycles the receiver refuses results in one go, once in the run.
  localparam int LONG_HOLD = 1500;
  // Cycle limit for the run; about 1200 keys plus sender gaps and receiver
  // stalls stay well under it.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int END_WAIT = 20000;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  length;
  } readout_t;

  // One row of the directed table. A row with whole set types arg as decimal
  // text, digit by digit; any other row is a single key with arg[3:0] as its
  // digit. Rows with typed set carry their expected result in want.
  typedef struct packed {
    bit          whole;
    logic [2:0]  act;
    logic [63:0] arg;
    bit          typed;
    readout_t    want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [3:0] digit, [7:4] zero
  logic [2:0]  s_axis_tuser = 3'd0;   // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;          // [63:0] result, [68:64] shown_length, [71:69] zero

  keypad_integer_calculator DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results still owed by the block, oldest first.
  readout_t readout_q [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned keys_sent = 0;
  int unsigned results_owed = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned ready_mode = 0;
  bit          hold_request = 1'b0;

  // Behavioral state of the calculator.
  logic [63:0]  calc_acc;
  logic [63:0]  calc_operand;
  kic_pkg::op_t calc_op;
  int unsigned  calc_chars;

  function automatic void report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [63:0] abs_u64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic void calc_clear();
    calc_acc = '0;
    calc_operand = '0;
    calc_op = kic_pkg::OP_ADD;
    calc_chars = 0;
  endfunction

  // Apply the pending operation to the accumulator and the typed operand.
  // Division works on magnitudes so that it truncates toward zero, and the
  // most negative value divided by minus one wraps back onto itself.
  function automatic void fold_operand();
    logic [63:0] quo;
    case (calc_op)
      kic_pkg::OP_ADD: calc_acc = calc_acc + calc_operand;
      kic_pkg::OP_SUB: calc_acc = calc_acc - calc_operand;
      kic_pkg::OP_MUL: calc_acc = calc_acc * calc_operand;
      kic_pkg::OP_DIV: begin
        // A zero divisor leaves the accumulator as it was.
        if (calc_operand != 64'd0) begin
          quo = abs_u64(calc_acc) / abs_u64(calc_operand);
          calc_acc = (calc_acc[63] ^ calc_operand[63]) ? 64'd0 - quo : quo;
        end
      end
    endcase
    calc_operand = '0;
  endfunction

  // Characters of the decimal text of v, minus sign included.
  function automatic logic [4:0] text_length(input logic [63:0] v);
    logic [63:0] m;
    int          n;
    m = abs_u64(v);
    n = 1;
    while (m >= 64'd10) begin
      m = m / 64'd10;
      n++;
    end
    return 5'(n + int'(v[63]));
  endfunction

  // Feed one key to the behavioral calculator; returns 1 when it yields a
  // result, which is left in ro.
  function automatic bit press_key(input logic [2:0] act, input logic [3:0] dig,
                                   output readout_t ro);
    ro = '0;
    if (act == kic_pkg::ACT_CLEAR) begin
      calc_clear();
      return 1'b0;
    end
    if (act == kic_pkg::ACT_EQ) begin
      fold_operand();
      ro.value = calc_acc;
      ro.length = text_length(calc_acc);
      // The shown text is taken as if typed afresh: its magnitude becomes the
      // operand, and a minus sign makes subtract the pending operation.
      calc_operand = abs_u64(calc_acc);
      calc_op = calc_acc[63] ? kic_pkg::OP_SUB : kic_pkg::OP_ADD;
      calc_chars = ro.length;
      calc_acc = '0;
      return 1'b1;
    end
    if (act == ACT_NONE) return 1'b0;
    if (act == kic_pkg::ACT_DIGIT && dig > 4'd9) return 1'b0;
    // Once the text is full, digits and operators are dropped.
    if (calc_chars >= kic_pkg::MAX_CHARS) return 1'b0;
    if (act == kic_pkg::ACT_DIGIT) begin
      calc_operand = calc_operand * 64'd10 + 64'(dig);
    end else begin
      fold_operand();
      calc_op = kic_pkg::op_t'(2'(act - kic_pkg::ACT_ADD));
    end
    calc_chars++;
    return 1'b0;
  endfunction

  // Hand one key to the block. The sender works in bursts; at the start of
  // each burst it may drop tvalid for a random gap. The beat is taken at the
  // first edge that sees tready high, and the key then goes to the predictor.
  task automatic send_key(input logic [2:0] act, input logic [3:0] dig,
                          input bit typed = 1'b0, input readout_t want = '0);
    int unsigned gap;
    readout_t    ro;
    bit          fires;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0000, dig};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    fires = press_key(act, dig, ro);
    if (fires) begin
      readout_q.push_back(typed ? want : ro);
      results_owed++;
    end
    if (!(act == ACT_NONE || (act == kic_pkg::ACT_DIGIT && dig > 4'd9))) keys_sent++;
  endtask

  // Type an unsigned value as decimal text, most significant digit first.
  // Values at or above 2^63 wrap into negative operands inside the block.
  task automatic type_number(input logic [63:0] v);
    logic [3:0] digs [20];
    int         n;
    n = 0;
    do begin
      digs[n] = 4'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 64'd0);
    for (int i = n - 1; i >= 0; i--) send_key(kic_pkg::ACT_DIGIT, digs[i]);
  endtask

  // Stop offering keys until every owed result has come back, then let the
  // block settle.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (readout_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Operands lean toward small numbers, with the edges of the word mixed in.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 31))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'h7FFF_FFFF_FFFF_FFFF;
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'hFFFF_FFFF_FFFF_FFFF;
      5:       return {$urandom, $urandom};
      6, 7:    return 64'($urandom);
      default: return 64'($urandom_range(0, 99));
    endcase
  endfunction

  // Receiver: checks each result beat against the oldest owed result, and
  // drives tready on one of four patterns, chosen at random. A long hold,
  // asked for by the stimulus, keeps tready low for a stretch set by LONG_HOLD.
  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata[63:0];
        got.length = m_axis_tdata[68:64];
        if (readout_q.size() == 0) begin
          report_failure($sformatf("result beat with none owed: value %0d length %0d",
                                   $signed(got.value), got.length));
        end else begin
          want = readout_q.pop_front();
          if (got.value !== want.value)
            report_failure($sformatf("result value: expected %0d, got %0d",
                                     $signed(want.value), $signed(got.value)));
          if (got.length !== want.length)
            report_failure($sformatf("shown length of %0d: expected %0d, got %0d",
                                     $signed(want.value), want.length, got.length));
        end
      end
      if (cycle_count % 97 == 0) ready_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= (cycle_count % 4 != 0);
          2:       m_axis_tready <= 1'($urandom);
          default: m_axis_tready <= (cycle_count % 8 == 0);
        endcase
      end
    end
  end

  // Directed keys. The opening equals sees the reset state. The largest value
  // plus one wraps to the most negative one, which is then divided by minus
  // one, typed as the digits of 2^64 - 1 that wrap the operand. Then come a
  // dropped digit above nine, an ignored action, a zero divisor, a division
  // that truncates toward zero, and a text that fills up so that further
  // digits and operators are dropped.
  step_t directed_steps [33];

  initial begin
    int unsigned terms;
    bit          long_hold_done;
    directed_steps = '{
      '{1'b0, kic_pkg::ACT_EQ,    64'd0, 1'b1, '{64'd0, 5'd1}},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd9223372036854775807, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_ADD,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd1, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_EQ,    64'd0, 1'b1, '{64'h8000_0000_0000_0000, 5'd20}},
      '{1'b0, kic_pkg::ACT_DIV,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_EQ,    64'd0, 1'b1, '{64'h8000_0000_0000_0000, 5'd20}},
      '{1'b0, kic_pkg::ACT_CLEAR, 64'd0, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIGIT, 64'd15, 1'b0, '0},
      '{1'b0, ACT_NONE,           64'd3, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIGIT, 64'd7, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_SUB,   64'd0, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIGIT, 64'd9, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIV,   64'd0, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIGIT, 64'd0, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_EQ,    64'd0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFE, 5'd2}},
      '{1'b0, kic_pkg::ACT_MUL,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd3, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIV,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd4, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_EQ,    64'd0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 5'd2}},
      '{1'b0, kic_pkg::ACT_CLEAR, 64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd1111111111111111111, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_ADD,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd1111111111111111111, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_ADD,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd1111111111111111111, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_ADD,   64'd0, 1'b0, '0},
      '{1'b1, kic_pkg::ACT_DIGIT, 64'd11, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_DIGIT, 64'd5, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_ADD,   64'd0, 1'b0, '0},
      '{1'b0, kic_pkg::ACT_EQ,    64'd0, 1'b1, '{64'd3333333333333333344, 5'd19}}
    };
    long_hold_done = 1'b0;
    calc_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].whole)
        type_number(directed_steps[i].arg);
      else
        send_key(directed_steps[i].act, directed_steps[i].arg[3:0],
                 directed_steps[i].typed, directed_steps[i].want);
    end
    wait_for_results();

    // Random expressions: mostly a clear, a few terms joined by random
    // operators and an equals. Some keep going from the reloaded value, some
    // lack the equals, and random keys are thrown in now and then. An
    // occasional long chain runs into the full text.
    keys_sent = 0;
    results_owed = 0;
    while (keys_sent < RANDOM_KEYS || results_owed < RANDOM_RESULTS) begin
      if ($urandom_range(0, 3) != 0) send_key(kic_pkg::ACT_CLEAR, 4'($urandom));
      terms = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
      for (int t = 0; t < terms; t++) begin
        if (t > 0 || $urandom_range(0, 4) == 0)
          send_key(3'($urandom_range(kic_pkg::ACT_ADD, kic_pkg::ACT_DIV)), 4'($urandom));
        type_number(pick_operand());
        if ($urandom_range(0, 15) == 0) send_key(3'($urandom), 4'($urandom));
      end
      if ($urandom_range(0, 9) != 0) send_key(kic_pkg::ACT_EQ, 4'($urandom));
      if ($urandom_range(0, 30) == 0) wait_for_results();
      // Partway through, the receiver stops for a long stretch while keys
      // keep coming, so that the block fills up and holds off its input.
      if (!long_hold_done && keys_sent > 400) begin
        hold_request = 1'b1;
        long_hold_done = 1'b1;
      end
    end

    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < END_WAIT && readout_q.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (readout_q.size() != 0)
      report_failure($sformatf("%0d results never arrived", readout_q.size()));
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
